>>> design/aad_pkg.sv
// ----------------------------------------------------------------------------
// aad_pkg
// shared constants for the area average image downscaler
// ----------------------------------------------------------------------------
package aad_pkg;

  localparam int DEF_WORK_MAX       = 1600;
  localparam int DEF_MAX_SOURCE_DIM = 16384;

  localparam int CH_W        = 8;   // colour channel
  localparam int COORD_W     = 11;  // output coordinate on the port
  localparam int SUM_W       = 20;  // column sum, kept modulo 2^SUM_W
  localparam int CFG_DATA_W  = 15;
  localparam int CFG_INDEX_W = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

endpackage

>>> design/aad_div.sv
// ----------------------------------------------------------------------------
// aad_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module aad_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    sh;
  logic [W:0]    diff;

  assign sh       = {rem, quo[W-1]};
  assign diff     = sh - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= sh[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> design/area_average_image_downscaler.sv
// ----------------------------------------------------------------------------
// area_average_image_downscaler
// box filter downscaler with per-column channel sums in one memory
// ----------------------------------------------------------------------------
// Source RGB pixels enter in raster order on the s_ side, one item per pixel,
// for an image whose width and height are written on the cfg port while the
// block is idle (0 reads as 1, sizes above MAX_SOURCE_DIM are clipped; a size
// write restarts the image). At the first pixel the output size is fitted so
// the long side is at most WORK_MAX, and each output pixel is the truncated
// mean of its source box, sent on the m_ side with its column and row once
// the last pixel of the box has come in; m_tlast marks the last output of the
// image. Column sums for the current band of output rows live in one
// synchronous memory of WORK_MAX words, read, updated and written back per
// pixel; no clearing pass is needed since the first pixel of a box overwrites
// its entry. One pixel is handled at a time: a pixel inside a box goes
// through accept, read, update and advance; every divide runs in the shared
// one-bit-a-cycle divider of DIVW bits (DIVW is 30 at the default sizes). A
// pixel that closes a column box needs one divide, the last pixel of a source
// row one, or two where it also closes a band of output rows (none at the
// end of the image), a pixel that closes an output box three more (and any
// wait for the output register), and the first pixel of an image up to three.
// ----------------------------------------------------------------------------
module area_average_image_downscaler #(
  parameter int WORK_MAX       = aad_pkg::DEF_WORK_MAX,
  parameter int MAX_SOURCE_DIM = aad_pkg::DEF_MAX_SOURCE_DIM
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aad_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [aad_pkg::CFG_DATA_W-1:0]     cfg_data,
  // source pixels
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [aad_pkg::IN_TDATA_W-1:0]     s_tdata,   // red_in, green_in, blue_in
  // output pixels
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [aad_pkg::OUT_TDATA_W-1:0]    m_tdata,   // red_out, green_out, blue_out,
                                                        // out_column, out_row, zero pad
  output logic                               m_tlast    // last_of_image
);

  localparam int CH_W  = aad_pkg::CH_W;
  localparam int SUM_W = aad_pkg::SUM_W;
  localparam int CO_W  = aad_pkg::COORD_W;
  localparam int SDW   = $clog2(MAX_SOURCE_DIM + 1);   // source sizes and positions
  localparam int OWD   = $clog2(WORK_MAX + 1);         // output sizes and box indexes
  localparam int AW    = (WORK_MAX > 1) ? $clog2(WORK_MAX) : 1;
  localparam int CNT_W = 2 * SDW;
  localparam int DW0   = OWD + 1 + SDW;
  localparam int DW1   = (DW0 > CNT_W) ? DW0 : CNT_W;
  localparam int DIVW  = (DW1 > SUM_W) ? DW1 : SUM_W;
  localparam int PAD_W = aad_pkg::OUT_TDATA_W - 3 * CH_W - 2 * CO_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SIZE, ST_CE, ST_RE, ST_RD, ST_ACC, ST_CNT,
    ST_DR, ST_DG, ST_DB, ST_EMIT, ST_ADV, ST_NCE, ST_NRE
  } state_t;

  state_t state;

  // image geometry
  logic [SDW-1:0]  src_w, src_h;
  logic [OWD-1:0]  out_w, out_h;
  // position in the source and the current box
  logic [SDW-1:0]  pos_x, pos_y;
  logic [OWD-1:0]  box_col, box_row;
  logic [SDW-1:0]  col_start, col_end, row_start, row_end;
  logic            row_pend;

  // current pixel and its box
  logic [CH_W-1:0]  pix_r, pix_g, pix_b;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [CNT_W-1:0] box_cnt;
  logic [CH_W-1:0]  q_r, q_g, q_b;
  logic             is_last;

  // column sum memory, one word holds all three channels
  logic [3*SUM_W-1:0] sums_mem [WORK_MAX];
  logic [3*SUM_W-1:0] rd_data;
  logic               mem_we;
  logic [3*SUM_W-1:0] wr_data;

  // shared divider
  logic            div_go;
  logic [DIVW-1:0] div_a, div_b;
  logic            div_done;
  logic [DIVW-1:0] div_q;
  logic [OWD-1:0]  size_q;

  logic            first_px;
  logic [SUM_W-1:0] acc_r, acc_g, acc_b;

  aad_div #(.W(DIVW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_ready = (state == ST_IDLE);
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;

  assign size_q   = (div_q == '0) ? OWD'(1) : OWD'(div_q);
  assign first_px = (pos_x == col_start) && (pos_y == row_start);
  assign acc_r    = first_px ? SUM_W'(pix_r) : rd_data[SUM_W-1:0] + SUM_W'(pix_r);
  assign acc_g    = first_px ? SUM_W'(pix_g) : rd_data[2*SUM_W-1:SUM_W] + SUM_W'(pix_g);
  assign acc_b    = first_px ? SUM_W'(pix_b) : rd_data[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_b);
  assign wr_data  = {acc_b, acc_g, acc_r};
  assign mem_we   = (state == ST_ACC);

  // memory: read in the read state, written back in the cycle after it
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums_mem[box_col[AW-1:0]] <= wr_data;
    end
    rd_data <= sums_mem[box_col[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      src_w    <= SDW'(1);
      src_h    <= SDW'(1);
      out_w    <= '0;
      out_h    <= '0;
      pos_x    <= '0;
      pos_y    <= '0;
      box_col  <= '0;
      box_row  <= '0;
      col_start <= '0;
      col_end  <= '0;
      row_start <= '0;
      row_end  <= '0;
      row_pend <= 1'b0;
      div_go   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      // the emit state refills the output register itself
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            unique case (cfg_index)
              aad_pkg::REG_SOURCE_WIDTH: begin
                src_w <= (cfg_data == '0) ? SDW'(1) :
                         (32'(cfg_data) > MAX_SOURCE_DIM) ? SDW'(MAX_SOURCE_DIM) :
                         SDW'(cfg_data);
                pos_x <= '0;
                pos_y <= '0;
              end
              aad_pkg::REG_SOURCE_HEIGHT: begin
                src_h <= (cfg_data == '0) ? SDW'(1) :
                         (32'(cfg_data) > MAX_SOURCE_DIM) ? SDW'(MAX_SOURCE_DIM) :
                         SDW'(cfg_data);
                pos_x <= '0;
                pos_y <= '0;
              end
              default: ;
            endcase
          end else if (s_tvalid) begin
            pix_r <= s_tdata[CH_W-1:0];
            pix_g <= s_tdata[2*CH_W-1:CH_W];
            pix_b <= s_tdata[3*CH_W-1:2*CH_W];
            if (pos_x == '0 && pos_y == '0) begin
              // new image: fit the output size, then the first box edges
              box_col   <= '0;
              box_row   <= '0;
              col_start <= '0;
              row_start <= '0;
              div_go    <= 1'b1;
              if (32'(src_w) > WORK_MAX || 32'(src_h) > WORK_MAX) begin
                div_a <= (src_w >= src_h) ? DIVW'(src_h) * DIVW'(WORK_MAX)
                                          : DIVW'(src_w) * DIVW'(WORK_MAX);
                div_b <= (src_w >= src_h) ? DIVW'(src_w) : DIVW'(src_h);
                state <= ST_SIZE;
              end else begin
                out_w <= OWD'(src_w);
                out_h <= OWD'(src_h);
                div_a <= DIVW'(src_w);
                div_b <= DIVW'(src_w);
                state <= ST_CE;
              end
            end else begin
              state <= ST_RD;
            end
          end
        end
        ST_SIZE: begin
          if (div_done) begin
            div_go <= 1'b1;
            div_a  <= DIVW'(src_w);
            if (src_w >= src_h) begin
              out_w <= OWD'(WORK_MAX);
              out_h <= size_q;
              div_b <= DIVW'(WORK_MAX);
            end else begin
              out_h <= OWD'(WORK_MAX);
              out_w <= size_q;
              div_b <= DIVW'(size_q);
            end
            state <= ST_CE;
          end
        end
        ST_CE: begin
          if (div_done) begin
            col_end <= SDW'(div_q);
            div_go  <= 1'b1;
            div_a   <= DIVW'(src_h);
            div_b   <= DIVW'(out_h);
            state   <= ST_RE;
          end
        end
        ST_RE: begin
          if (div_done) begin
            row_end <= SDW'(div_q);
            state   <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum_r   <= acc_r;
          sum_g   <= acc_g;
          sum_b   <= acc_b;
          box_cnt <= CNT_W'(col_end - col_start) * CNT_W'(row_end - row_start);
          is_last <= (box_col + OWD'(1) == out_w) && (box_row + OWD'(1) == out_h);
          if (pos_x + SDW'(1) == col_end && pos_y + SDW'(1) == row_end) begin
            state <= ST_CNT;
          end else begin
            state <= ST_ADV;
          end
        end
        ST_CNT: begin
          div_go <= 1'b1;
          div_a  <= DIVW'(sum_r);
          div_b  <= (box_cnt == '0) ? DIVW'(1) : DIVW'(box_cnt);
          state  <= ST_DR;
        end
        ST_DR: begin
          if (div_done) begin
            q_r    <= div_q[CH_W-1:0];
            div_go <= 1'b1;
            div_a  <= DIVW'(sum_g);
            state  <= ST_DG;
          end
        end
        ST_DG: begin
          if (div_done) begin
            q_g    <= div_q[CH_W-1:0];
            div_go <= 1'b1;
            div_a  <= DIVW'(sum_b);
            state  <= ST_DB;
          end
        end
        ST_DB: begin
          if (div_done) begin
            q_b   <= div_q[CH_W-1:0];
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // wait for the output register to be free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {PAD_W'(0), CO_W'(box_row), CO_W'(box_col), q_b, q_g, q_r};
            m_tlast  <= is_last;
            state    <= ST_ADV;
          end
        end
        ST_ADV: begin
          if (pos_x + SDW'(1) == src_w) begin
            // end of a source row
            pos_x     <= '0;
            box_col   <= '0;
            col_start <= '0;
            if (pos_y + SDW'(1) == src_h) begin
              pos_y <= '0;
              state <= ST_IDLE;
            end else begin
              pos_y    <= pos_y + SDW'(1);
              row_pend <= (pos_y + SDW'(1) == row_end);
              if (pos_y + SDW'(1) == row_end) begin
                box_row   <= box_row + OWD'(1);
                row_start <= row_end;
              end
              div_go <= 1'b1;
              div_a  <= DIVW'(src_w);
              div_b  <= DIVW'(out_w);
              state  <= ST_NCE;
            end
          end else begin
            pos_x    <= pos_x + SDW'(1);
            row_pend <= 1'b0;
            if (pos_x + SDW'(1) == col_end) begin
              box_col   <= box_col + OWD'(1);
              col_start <= col_end;
              div_go    <= 1'b1;
              div_a     <= DIVW'(DIVW'(box_col) + DIVW'(2)) * DIVW'(src_w);
              div_b     <= DIVW'(out_w);
              state     <= ST_NCE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_NCE: begin
          if (div_done) begin
            col_end <= SDW'(div_q);
            if (row_pend) begin
              // box_row already points at the new band
              div_go <= 1'b1;
              div_a  <= DIVW'(DIVW'(box_row) + DIVW'(1)) * DIVW'(src_h);
              div_b  <= DIVW'(out_h);
              state  <= ST_NRE;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_NRE: begin
          if (div_done) begin
            row_end <= SDW'(div_q);
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
